// File: sv/mcfprm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcfprm_pkg: shared definitions for the flow pulse rate meter
// Channel count, constants, operation codes and register indexes.
// ----------------------------------------------------------------------------
package mcfprm_pkg;

  // Number of pulse channels and the width of a channel index.
  localparam int unsigned CHANNELS = 3;
  localparam int unsigned CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Number of pin bits carried by a sample.
  localparam int unsigned PIN_BITS = 3;

  // Milliseconds per minute, used as the serial multiplier constant.
  localparam logic [15:0] MS_PER_MINUTE = 16'd60000;

  // Reset value of the minimum window register.
  localparam logic [15:0] WINDOW_RESET = 16'd100;

  // Previous pin levels after reset.
  localparam logic [PIN_BITS-1:0] PINS_ALL_HIGH = 3'd7;

  // Operation codes carried in the input tuser.
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_RESET  = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  // Configuration register indexes.
  localparam logic REG_MIN_WINDOW = 1'b0;

endpackage

// File: sv/multi_channel_flow_pulse_rate_meter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_flow_pulse_rate_meter_core: three-channel pulse rate meter
// Counts falling edges per channel and reports pulses per minute, computed
// with a bit-serial multiplier and a bit-serial restoring divider.
// ----------------------------------------------------------------------------
// Pin samples and channel resets are taken in the idle state and give no result.
// A read that holds its rate, or names a bad channel, goes straight to the output state.
// A recomputing read runs 16 multiply steps by 60000, one saturation check and
// 32 divide steps; a saturated rate skips the divide.
// One item is worked on at a time; the input is ready again once the result
// sits in the output register. rst_ni clears all counters asynchronously.

module multi_channel_flow_pulse_rate_meter_core (
  input  logic        clk_i,
  input  logic        rst_ni,

  // Input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: pins[2:0], channel[5:3], now_ms[37:6], zero fill[39:38]
  input  logic [39:0] s_axis_tdata_i,
  // tuser: op[1:0]
  input  logic [1:0]  s_axis_tuser_i,

  // Result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata: pulse_count[31:0], rate_per_min[63:32]
  output logic [63:0] m_axis_tdata_o,
  // tuser: rate_fresh[0], bad_channel[1]
  output logic [1:0]  m_axis_tuser_o,

  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CH    = mcfprm_pkg::CHANNELS;
  localparam int unsigned IDX_W = mcfprm_pkg::CH_IDX_W;
  localparam int unsigned PB    = mcfprm_pkg::PIN_BITS;

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_CHK  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  // Configuration register
  logic [15:0] min_window_q;

  // Per-channel state
  logic [PB-1:0] prev_pins_q;
  logic [31:0]   edge_count_q   [CH];
  logic [31:0]   win_count_q    [CH];
  logic [31:0]   win_time_q     [CH];
  logic [31:0]   held_rate_q    [CH];

  // Sequencer and datapath
  logic [2:0]       state_q;
  logic [4:0]       cnt_q;
  logic [31:0]      delta_q;
  logic [31:0]      elapsed_q;
  logic [47:0]      acc_q;
  logic [31:0]      rem_q;
  logic [IDX_W-1:0] ch_q;

  // Pending result
  logic [31:0] res_count_q;
  logic [31:0] res_rate_q;
  logic        res_fresh_q;
  logic        res_bad_q;

  // Output register
  logic        out_valid_q;
  logic [63:0] out_data_q;
  logic [1:0]  out_user_q;

  // Input field decode
  logic [1:0]       in_op;
  logic [PB-1:0]    in_pins;
  logic [2:0]       in_channel;
  logic [31:0]      in_now;
  logic             in_fire;
  logic             ch_valid;
  logic [IDX_W-1:0] ch_idx;
  logic [31:0]      elapsed;
  logic [15:0]      window;
  logic             window_open;

  assign in_op      = s_axis_tuser_i;
  assign in_pins    = s_axis_tdata_i[2:0];
  assign in_channel = s_axis_tdata_i[5:3];
  assign in_now     = s_axis_tdata_i[37:6];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  assign ch_valid = ({1'b0, in_channel} < 4'(CH));
  assign ch_idx   = in_channel[IDX_W-1:0];

  // Elapsed time since the window start and the effective minimum window.
  assign elapsed     = in_now - win_time_q[ch_idx];
  assign window      = (min_window_q == 16'd0) ? 16'd1 : min_window_q;
  assign window_open = (elapsed < {16'd0, window});

  // Divider step: shift one dividend bit into the partial remainder.
  logic [32:0] trial;
  logic        trial_ge;
  assign trial    = {rem_q, acc_q[31]};
  assign trial_ge = (trial >= {1'b0, elapsed_q});

  // Saturation check: the quotient overflows 32 bits when the upper product
  // bits already reach the divisor.
  logic saturate;
  assign saturate = ({16'd0, acc_q[47:32]} >= elapsed_q);

  logic out_load;
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready_i);

  // Configuration port
  logic cfg_write;
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == mcfprm_pkg::REG_MIN_WINDOW) ? {16'd0, min_window_q}
                                                              : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_window_q <= mcfprm_pkg::WINDOW_RESET;
    end else if (cfg_write && (paddr[2] == mcfprm_pkg::REG_MIN_WINDOW)) begin
      min_window_q <= pwdata[15:0];
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire && (in_op == mcfprm_pkg::OP_READ)) begin
            if (ch_valid && !window_open) begin
              state_q <= ST_MUL;
              cnt_q   <= 5'd15;
            end else begin
              state_q <= ST_OUT;
            end
          end
        end
        ST_MUL: begin
          if (cnt_q == 5'd0) begin
            state_q <= ST_CHK;
          end else begin
            cnt_q <= cnt_q - 5'd1;
          end
        end
        ST_CHK: begin
          if (saturate) begin
            state_q <= ST_OUT;
          end else begin
            state_q <= ST_DIV;
            cnt_q   <= 5'd31;
          end
        end
        ST_DIV: begin
          if (cnt_q == 5'd0) begin
            state_q <= ST_OUT;
          end else begin
            cnt_q <= cnt_q - 5'd1;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath: operands, serial multiply, serial divide and pending result.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_fire && (in_op == mcfprm_pkg::OP_READ)) begin
          ch_q        <= ch_idx;
          delta_q     <= edge_count_q[ch_idx] - win_count_q[ch_idx];
          elapsed_q   <= elapsed;
          acc_q       <= '0;
          res_count_q <= ch_valid ? edge_count_q[ch_idx] : 32'd0;
          res_rate_q  <= (ch_valid && window_open) ? held_rate_q[ch_idx] : 32'd0;
          res_fresh_q <= ch_valid && !window_open;
          res_bad_q   <= !ch_valid;
        end
      end
      ST_MUL: begin
        // Multiplier bits of 60000 taken from the top down.
        acc_q <= {acc_q[46:0], 1'b0}
               + (mcfprm_pkg::MS_PER_MINUTE[cnt_q[3:0]] ? {16'd0, delta_q} : 48'd0);
      end
      ST_CHK: begin
        rem_q <= {16'd0, acc_q[47:32]};
        if (saturate) begin
          res_rate_q <= 32'hFFFF_FFFF;
        end
      end
      ST_DIV: begin
        rem_q        <= trial_ge ? 32'(trial - {1'b0, elapsed_q}) : trial[31:0];
        acc_q[31:0]  <= {acc_q[30:0], trial_ge};
        if (cnt_q == 5'd0) begin
          res_rate_q <= {acc_q[30:0], trial_ge};
        end
      end
      default: begin
      end
    endcase
  end

  // Per-channel counters, window marks and held rates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_pins_q <= mcfprm_pkg::PINS_ALL_HIGH;
      for (int c = 0; c < CH; c++) begin
        edge_count_q[c] <= '0;
        win_count_q[c]  <= '0;
        win_time_q[c]   <= '0;
        held_rate_q[c]  <= '0;
      end
    end else begin
      if (in_fire) begin
        case (in_op)
          mcfprm_pkg::OP_SAMPLE: begin
            // Count a falling edge where the pin was high and is now low.
            for (int c = 0; c < CH; c++) begin
              if (c < PB) begin
                if (prev_pins_q[c] && !in_pins[c]) begin
                  edge_count_q[c] <= edge_count_q[c] + 32'd1;
                end
              end
            end
            prev_pins_q <= in_pins;
          end
          mcfprm_pkg::OP_RESET: begin
            if (ch_valid) begin
              edge_count_q[ch_idx] <= '0;
              win_count_q[ch_idx]  <= '0;
              win_time_q[ch_idx]   <= in_now;
            end
          end
          mcfprm_pkg::OP_READ: begin
            // A recompute restarts the window at once; the rate follows later.
            if (ch_valid && !window_open) begin
              win_count_q[ch_idx] <= edge_count_q[ch_idx];
              win_time_q[ch_idx]  <= in_now;
            end
          end
          default: begin
          end
        endcase
      end
      if (out_load && res_fresh_q) begin
        held_rate_q[ch_q] <= res_rate_q;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {res_rate_q, res_count_q};
      out_user_q <= {res_bad_q, res_fresh_q};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the flow pulse rate meter core
// A queue-fed driver offers pin samples, channel resets and reads on the
// input stream. A monitor predicts each reading from its own copy of the
// counters and windows, and compares every output transfer field by field.
// The window register is rewritten between phases of differing idle rates.
// ----------------------------------------------------------------------------
module testbench;

  localparam int          HALF_PERIOD   = 4;
  localparam int          RESET_CYCLES  = 5;
  localparam int          SETTLE_CYCLES = 64;
  localparam int          HOLD_CYCLES   = 600;
  localparam logic [1:0]  OP_UNUSED     = 2'd3;
  localparam logic [2:0]  MIN_WINDOW_ADDR = {mcfprm_pkg::REG_MIN_WINDOW, 2'b00};

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  pins;
    logic [2:0]  channel;
    logic [31:0] now_ms;
  } meter_item_t;

  typedef struct packed {
    logic [31:0] pulse_count;
    logic [31:0] rate_per_min;
    logic        rate_fresh;
    logic        bad_channel;
  } meter_reading_t;

  // Clock, reset and block inputs, all known from time zero.
  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [39:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = '0;
  logic        m_tready = 1'b0;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;

  logic        s_tready;
  logic        m_tvalid;
  logic [63:0] m_tdata;
  logic [1:0]  m_tuser;
  logic [31:0] prdata;
  logic        pready;

  // Bench bookkeeping.
  meter_item_t    pending_items[$];
  meter_reading_t expected_readings[$];
  int   items_unaccepted = 0;
  int   mismatch_count   = 0;
  int   send_idle_pct    = 0;
  int   recv_stall_pct   = 0;
  logic in_taken         = 1'b0;
  logic hold_off         = 1'b0;
  bit   pressure_armed   = 1'b0;
  logic [31:0] sim_ms    = '0;

  // Predicted block state.
  logic [15:0]                    window_cfg = mcfprm_pkg::WINDOW_RESET;
  logic [mcfprm_pkg::PIN_BITS-1:0] last_pins = mcfprm_pkg::PINS_ALL_HIGH;
  logic [31:0]         edges[mcfprm_pkg::CHANNELS];
  logic [31:0]         win_count[mcfprm_pkg::CHANNELS];
  logic [31:0]         win_time[mcfprm_pkg::CHANNELS];
  logic [31:0]         rate_hold[mcfprm_pkg::CHANNELS];

  multi_channel_flow_pulse_rate_meter_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Advance the predicted state by one item; returns 1 when a reading results.
  function automatic bit predict_meter(input meter_item_t it, output meter_reading_t rd);
    logic [31:0] win;
    logic [31:0] span;
    logic [31:0] delta;
    logic [63:0] quot;
    rd = '0;
    case (it.op)
      mcfprm_pkg::OP_SAMPLE: begin
        for (int c = 0; c < mcfprm_pkg::CHANNELS && c < mcfprm_pkg::PIN_BITS; c++) begin
          if (last_pins[c] && !it.pins[c]) edges[c] = edges[c] + 32'd1;
        end
        last_pins = it.pins;
        return 1'b0;
      end
      mcfprm_pkg::OP_RESET: begin
        if (it.channel < mcfprm_pkg::CHANNELS) begin
          edges[it.channel]     = '0;
          win_count[it.channel] = '0;
          win_time[it.channel]  = it.now_ms;
        end
        return 1'b0;
      end
      mcfprm_pkg::OP_READ: begin
        if (it.channel >= mcfprm_pkg::CHANNELS) begin
          rd.bad_channel = 1'b1;
          return 1'b1;
        end
        // A zero window behaves as one millisecond.
        win  = (window_cfg == '0) ? 32'd1 : 32'(window_cfg);
        span = it.now_ms - win_time[it.channel];
        rd.pulse_count = edges[it.channel];
        if (span < win) begin
          rd.rate_per_min = rate_hold[it.channel];
        end else begin
          delta = edges[it.channel] - win_count[it.channel];
          quot  = (64'(delta) * 64'(mcfprm_pkg::MS_PER_MINUTE)) / 64'(span);
          rd.rate_per_min = (quot > 64'h0000_0000_FFFF_FFFF) ? '1 : quot[31:0];
          rd.rate_fresh   = 1'b1;
          rate_hold[it.channel] = rd.rate_per_min;
          win_count[it.channel] = edges[it.channel];
          win_time[it.channel]  = it.now_ms;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic meter_item_t mk_item(input logic [1:0] op, input logic [2:0] pins,
                                          input logic [2:0] channel, input logic [31:0] now_ms);
    meter_item_t it;
    it.op      = op;
    it.pins    = pins;
    it.channel = channel;
    it.now_ms  = now_ms;
    return it;
  endfunction

  task automatic push_item(input meter_item_t it);
    pending_items.push_back(it);
    items_unaccepted++;
  endtask

  // Write the window register, then read it back.
  task automatic set_min_window(input logic [15:0] window);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MIN_WINDOW_ADDR;
    pwdata  <= 32'(window);
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    window_cfg = window;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[15:0] !== window) begin
      $display("%0t: min_window_ms readback expected %0d, got %0d", $time, window,
               prdata[15:0]);
      mismatch_count++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Wait until every item is taken and every reading has arrived, then settle.
  task automatic wait_drained();
    do @(negedge clk_i); while (items_unaccepted != 0 || expected_readings.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Mostly well-formed traffic on an advancing clock, with some raw noise.
  task automatic queue_random(input int target, input int step_max);
    meter_item_t it;
    int counted;
    int roll;
    counted = 0;
    while (counted < target) begin
      if ($urandom_range(0, 99) < 85) begin
        sim_ms     = sim_ms + $urandom_range(0, step_max);
        it.now_ms  = sim_ms;
        it.pins    = 3'($urandom_range(0, 7));
        it.channel = ($urandom_range(0, 9) < 9)
                   ? 3'($urandom_range(0, mcfprm_pkg::CHANNELS - 1))
                   : 3'($urandom_range(mcfprm_pkg::CHANNELS, 7));
        roll = $urandom_range(0, 99);
        if (roll < 55)      it.op = mcfprm_pkg::OP_SAMPLE;
        else if (roll < 90) it.op = mcfprm_pkg::OP_READ;
        else                it.op = mcfprm_pkg::OP_RESET;
      end else begin
        it.op      = 2'($urandom_range(0, 3));
        it.pins    = 3'($urandom);
        it.channel = 3'($urandom);
        it.now_ms  = $urandom;
      end
      push_item(it);
      if (!(it.op == OP_UNUSED ||
            (it.op == mcfprm_pkg::OP_RESET && it.channel >= mcfprm_pkg::CHANNELS)))
        counted++;
    end
  endtask

  task automatic run_phase(input logic [15:0] window, input int send_pct, input int stall_pct,
                           input int count, input logic [31:0] start_ms);
    int step_max;
    set_min_window(window);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    sim_ms         = start_ms;
    step_max       = 2 * ((window == '0) ? 1 : int'(window)) + 1;
    queue_random(count, step_max);
    wait_drained();
  endtask

  // Input driver: present the next pending item once the last one transferred.
  always @(negedge clk_i) begin : driver
    meter_item_t it;
    if (rst_ni && (!s_tvalid || in_taken)) begin
      if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        it = pending_items.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, it.now_ms, it.channel, it.pins};
        s_tuser  <= it.op;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Output ready: random stalls, forced low during a hold-off.
  always @(negedge clk_i) begin : sink
    m_tready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Long receiver hold-off so the block backs up onto its input.
  initial begin : pressure
    wait (pressure_armed);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Monitor: predict on each input transfer, check each output transfer.
  always @(posedge clk_i) begin : monitor
    meter_item_t    taken;
    meter_reading_t predicted;
    meter_reading_t wanted;
    meter_reading_t got;
    in_taken <= s_tvalid && s_tready;
    if (rst_ni) begin
      if (s_tvalid && s_tready) begin
        taken.op      = s_tuser;
        taken.pins    = s_tdata[2:0];
        taken.channel = s_tdata[5:3];
        taken.now_ms  = s_tdata[37:6];
        if (predict_meter(taken, predicted)) expected_readings.push_back(predicted);
        items_unaccepted--;
      end
      if (m_tvalid && m_tready) begin
        got.pulse_count  = m_tdata[31:0];
        got.rate_per_min = m_tdata[63:32];
        got.rate_fresh   = m_tuser[0];
        got.bad_channel  = m_tuser[1];
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected reading, expected none, got count %0d rate %0d",
                   $time, got.pulse_count, got.rate_per_min);
          mismatch_count++;
        end else begin
          wanted = expected_readings.pop_front();
          if (got.pulse_count !== wanted.pulse_count) begin
            $display("%0t: pulse_count expected %0d, got %0d", $time,
                     wanted.pulse_count, got.pulse_count);
            mismatch_count++;
          end
          if (got.rate_per_min !== wanted.rate_per_min) begin
            $display("%0t: rate_per_min expected %0d, got %0d", $time,
                     wanted.rate_per_min, got.rate_per_min);
            mismatch_count++;
          end
          if (got.rate_fresh !== wanted.rate_fresh) begin
            $display("%0t: rate_fresh expected %0b, got %0b", $time,
                     wanted.rate_fresh, got.rate_fresh);
            mismatch_count++;
          end
          if (got.bad_channel !== wanted.bad_channel) begin
            $display("%0t: bad_channel expected %0b, got %0b", $time,
                     wanted.bad_channel, got.bad_channel);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Run limit.
  initial begin : watchdog
    #8_000_000;
    $display("multi_channel_flow_pulse_rate_meter_core: mismatch");
    $finish;
  end

  // Main sequence: reset, directed items, then randomized phases.
  initial begin : sequencer
    for (int c = 0; c < mcfprm_pkg::CHANNELS; c++) begin
      edges[c]     = '0;
      win_count[c] = '0;
      win_time[c]  = '0;
      rate_hold[c] = '0;
    end
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed items at the reset window of 100 ms.
    push_item(mk_item(mcfprm_pkg::OP_READ, 3'd0, 3'd0, 32'd0));     // held, nothing elapsed
    push_item(mk_item(mcfprm_pkg::OP_SAMPLE, 3'd0, 3'd0, 32'd1));   // all three fall
    push_item(mk_item(mcfprm_pkg::OP_SAMPLE, 3'd7, 3'd0, 32'd2));
    push_item(mk_item(mcfprm_pkg::OP_SAMPLE, 3'd5, 3'd0, 32'd3));   // channel 1 falls
    push_item(mk_item(mcfprm_pkg::OP_SAMPLE, 3'd2, 3'd0, 32'd4));   // channels 0 and 2 fall
    push_item(mk_item(mcfprm_pkg::OP_READ, 3'd0, 3'd0, 32'd99));    // one short of the window
    push_item(mk_item(mcfprm_pkg::OP_READ, 3'd0, 3'd0, 32'd100));   // exactly the window
    push_item(mk_item(mcfprm_pkg::OP_READ, 3'd0, 3'd1, 32'd150));
    push_item(mk_item(mcfprm_pkg::OP_READ, 3'd7, 3'd2, 32'hFFFF_FFFF)); // huge elapsed time
    push_item(mk_item(mcfprm_pkg::OP_READ, 3'd0, 3'd3, 32'd160));   // first bad channel
    push_item(mk_item(mcfprm_pkg::OP_READ, 3'd7, 3'd7, 32'd170));   // last bad channel
    push_item(mk_item(mcfprm_pkg::OP_RESET, 3'd0, 3'd1, 32'd200));
    push_item(mk_item(mcfprm_pkg::OP_RESET, 3'd0, 3'd5, 32'd205));  // ignored reset
    push_item(mk_item(OP_UNUSED, 3'd0, 3'd0, 32'd207));             // ignored op code
    push_item(mk_item(mcfprm_pkg::OP_SAMPLE, 3'd7, 3'd0, 32'd210));
    push_item(mk_item(mcfprm_pkg::OP_SAMPLE, 3'd0, 3'd0, 32'd220));
    push_item(mk_item(mcfprm_pkg::OP_READ, 3'd0, 3'd1, 32'd250));   // held rate
    push_item(mk_item(mcfprm_pkg::OP_READ, 3'd0, 3'd1, 32'd300));
    push_item(mk_item(mcfprm_pkg::OP_READ, 3'd0, 3'd0, 32'd300));
    push_item(mk_item(mcfprm_pkg::OP_RESET, 3'd0, 3'd0, 32'hFFFF_FFF0));
    push_item(mk_item(mcfprm_pkg::OP_SAMPLE, 3'd7, 3'd0, 32'hFFFF_FFF8));
    push_item(mk_item(mcfprm_pkg::OP_SAMPLE, 3'd0, 3'd0, 32'hFFFF_FFFC));
    push_item(mk_item(mcfprm_pkg::OP_READ, 3'd0, 3'd0, 32'h0000_0060)); // window spans the wrap
    push_item(mk_item(mcfprm_pkg::OP_READ, 3'd0, 3'd2, 32'hFFFF_FFFF)); // held, nothing elapsed
    wait_drained();

    // Randomized phases across window settings and idle patterns.
    run_phase(16'd1,    0,  0,  300, 32'hFFFF_FF80);
    run_phase(16'hFFFF, 68, 0,  300, $urandom);
    run_phase(16'd0,    0,  68, 300, $urandom);
    run_phase(16'($urandom_range(2, 500)), 9, 9, 300, $urandom);
    pressure_armed = 1'b1;
    run_phase(mcfprm_pkg::WINDOW_RESET, 0, 0, 300, $urandom);
    run_phase(16'($urandom_range(2, 5000)), 0, 0, 400, $urandom);

    if (mismatch_count == 0) begin
      $display("multi_channel_flow_pulse_rate_meter_core: match");
    end else begin
      $display("multi_channel_flow_pulse_rate_meter_core: mismatch");
    end
    $finish;
  end

endmodule
